>>> design/mcsp_pkg.sv
// shared types and constants for the mqtt connect stream parser
package mcsp_pkg;

  localparam logic [2:0] KIND_FIXED   = 3'd0;
  localparam logic [2:0] KIND_CONNECT = 3'd1;
  localparam logic [2:0] KIND_STR_LEN = 3'd2;
  localparam logic [2:0] KIND_STR_BYTE = 3'd3;
  localparam logic [2:0] KIND_CONNACK = 3'd4;

  localparam logic [3:0] TYPE_CONNECT = 4'd1;

  localparam logic [2:0] TAG_PROTO_NAME = 3'd0;
  localparam logic [2:0] TAG_CLIENT_ID  = 3'd1;
  localparam logic [2:0] TAG_WILL_TOPIC = 3'd2;
  localparam logic [2:0] TAG_WILL_MSG   = 3'd3;
  localparam logic [2:0] TAG_USER       = 3'd4;
  localparam logic [2:0] TAG_PASSWORD   = 3'd5;

  localparam logic [7:0] CONNACK_BYTE0 = 8'h20;
  localparam logic [7:0] CONNACK_BYTE1 = 8'h02;
  localparam logic [7:0] CONNACK_ZERO  = 8'h00;
  localparam logic [2:0] CONNACK_LEN   = 3'd4;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [27:0] rem_len;
    logic [7:0]  proto_level;
    logic [7:0]  connect_flags;
    logic [15:0] ka_secs;
    logic [2:0]  string_tag;
    logic [15:0] string_length;
    logic [7:0]  out_byte;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic       found;
    logic [2:0] tag;
  } next_field_t;

endpackage

>>> design/mcsp_in_if.sv
// input byte channel of the mqtt connect stream parser
interface mcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source(output valid, data_byte, packet_start, input ready);
  modport sink(input valid, data_byte, packet_start, output ready);
endinterface

>>> design/mcsp_out_if.sv
// result record channel of the mqtt connect stream parser
interface mcsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [3:0]  packet_type;
  logic [3:0]  header_flags;
  logic [27:0] rem_len;
  logic [7:0]  proto_level;
  logic [7:0]  connect_flags;
  logic [15:0] ka_secs;
  logic [2:0]  string_tag;
  logic [15:0] string_length;
  logic [7:0]  out_byte;
  logic        last;

  modport source(output valid, record_kind, packet_type, header_flags, rem_len,
                 proto_level, connect_flags, ka_secs, string_tag, string_length,
                 out_byte, last, input ready);
  modport sink(input valid, record_kind, packet_type, header_flags, rem_len,
               proto_level, connect_flags, ka_secs, string_tag, string_length,
               out_byte, last, output ready);
endinterface

>>> design/mqtt_connect_stream_parser.sv
// mqtt connect stream parser top level: header decode, field walk and connack replay
//
//   channel  | dir | handshake     | payload
//   in_s     | in  | valid / ready | data_byte, packet_start
//   out_m    | out | valid / ready | record fields, last
//
// one input byte is taken per cycle while out_m keeps up; its state update is done in the accept cycle
// and any result item shows on out_m the next cycle from the output register
// the final byte of the last field yields five items (record plus four connack
// bytes), so in_s stalls there until the last connack byte is being taken
// rst_n clears the parser phase and empties the output register; bytes before a start are dropped
// in_s.ready is low while the output register holds items beyond the one being taken
module mqtt_connect_stream_parser
  import mcsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mcsp_in_if.sink   in_s,
  mcsp_out_if.source out_m
);

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_LEN      = 10'b00_0000_0010,
    PH_STR_HI   = 10'b00_0000_0100,
    PH_STR_LO   = 10'b00_0000_1000,
    PH_STR_BODY = 10'b00_0001_0000,
    PH_LEVEL    = 10'b00_0010_0000,
    PH_FLAGS    = 10'b00_0100_0000,
    PH_KA_HI    = 10'b00_1000_0000,
    PH_KA_LO    = 10'b01_0000_0000,
    PH_SKIP     = 10'b10_0000_0000
  } phase_t;

  function automatic logic tag_present(input logic [2:0] t, input logic [7:0] cf);
    logic p;
    p = 1'b1;
    if (t == TAG_WILL_TOPIC || t == TAG_WILL_MSG) p = cf[2];
    else if (t == TAG_USER) p = cf[6];
    else if (t == TAG_PASSWORD) p = cf[7];
    return p;
  endfunction

  function automatic next_field_t next_field(input logic [2:0] cur, input logic [7:0] cf);
    next_field_t nf;
    nf = '0;
    for (int t = 1; t <= 5; t++) begin
      if (!nf.found && 3'(t) > cur && tag_present(3'(t), cf)) begin
        nf.found = 1'b1;
        nf.tag   = 3'(t);
      end
    end
    return nf;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [27:0] accum_r, accum_nxt;
  logic [1:0]  len_cnt_r, len_cnt_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [3:0]  hflags_r, hflags_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [7:0]  cflags_r, cflags_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [2:0]  tag_r, tag_nxt;
  logic [15:0] left_r, left_nxt;

  rec_t        rec_r, rec_c;
  logic        rec_pend_r, rec_pend_nxt;
  logic [2:0]  ack_cnt_r, ack_cnt_nxt;
  logic        rec_ok, ack_go;

  logic [7:0]  b;
  logic [27:0] len_part;
  logic [27:0] acc;
  logic [15:0] str_len;
  logic [15:0] left_dec;
  next_field_t nf;
  logic        in_fire, out_fire, out_valid, last_piece;
  rec_t        ack_rec, out_rec;

  assign b        = in_s.data_byte;
  assign str_len  = {hold_r, b};
  assign left_dec = left_r - 16'd1;
  assign nf       = next_field(tag_r, cflags_r);

  always_comb begin
    case (len_cnt_r)
      2'd0:    len_part = {21'd0, b[6:0]};
      2'd1:    len_part = {14'd0, b[6:0], 7'd0};
      2'd2:    len_part = {7'd0, b[6:0], 14'd0};
      default: len_part = {b[6:0], 21'd0};
    endcase
  end
  assign acc = accum_r | len_part;

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    len_cnt_nxt = len_cnt_r;
    type_nxt    = type_r;
    hflags_nxt  = hflags_r;
    level_nxt   = level_r;
    cflags_nxt  = cflags_r;
    hold_nxt    = hold_r;
    tag_nxt     = tag_r;
    left_nxt    = left_r;
    rec_c       = '0;
    rec_ok      = 1'b0;
    ack_go      = 1'b0;
    if (in_s.packet_start) begin
      type_nxt    = b[7:4];
      hflags_nxt  = b[3:0];
      accum_nxt   = '0;
      len_cnt_nxt = '0;
      phase_nxt   = PH_LEN;
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          accum_nxt = acc;
          if (!b[7] || len_cnt_r == 2'd3) begin
            rec_ok             = 1'b1;
            rec_c.record_kind  = KIND_FIXED;
            rec_c.packet_type  = type_r;
            rec_c.header_flags = hflags_r;
            rec_c.rem_len      = acc;
            if (type_r == TYPE_CONNECT) begin
              tag_nxt   = TAG_PROTO_NAME;
              phase_nxt = PH_STR_HI;
            end else begin
              rec_c.last = 1'b1;
              phase_nxt  = PH_SKIP;
            end
          end else begin
            len_cnt_nxt = len_cnt_r + 2'd1;
          end
        end
        PH_STR_HI: begin
          hold_nxt  = b;
          phase_nxt = PH_STR_LO;
        end
        PH_STR_LO, PH_STR_BODY: begin
          rec_ok           = 1'b1;
          rec_c.string_tag = tag_r;
          if (phase_r == PH_STR_LO) begin
            rec_c.record_kind   = KIND_STR_LEN;
            rec_c.string_length = str_len;
            left_nxt            = str_len;
          end else begin
            rec_c.record_kind = KIND_STR_BYTE;
            rec_c.out_byte    = b;
            left_nxt          = left_dec;
          end
          if (left_nxt == 16'd0) begin
            rec_c.last = 1'b1;
            if (tag_r == TAG_PROTO_NAME) begin
              phase_nxt = PH_LEVEL;
            end else if (nf.found) begin
              tag_nxt   = nf.tag;
              phase_nxt = PH_STR_HI;
            end else begin
              ack_go    = 1'b1;
              phase_nxt = PH_SKIP;
            end
          end else begin
            phase_nxt = PH_STR_BODY;
          end
        end
        PH_LEVEL: begin
          level_nxt = b;
          phase_nxt = PH_FLAGS;
        end
        PH_FLAGS: begin
          cflags_nxt = b;
          phase_nxt  = PH_KA_HI;
        end
        PH_KA_HI: begin
          hold_nxt  = b;
          phase_nxt = PH_KA_LO;
        end
        PH_KA_LO: begin
          rec_ok              = 1'b1;
          rec_c.record_kind   = KIND_CONNECT;
          rec_c.proto_level   = level_r;
          rec_c.connect_flags = cflags_r;
          rec_c.ka_secs       = str_len;
          tag_nxt             = TAG_CLIENT_ID;
          phase_nxt           = PH_STR_HI;
        end
        PH_IDLE, PH_SKIP: begin
          phase_nxt = phase_r;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // output register: one pending record followed by up to four connack bytes
  assign out_valid  = rec_pend_r || (ack_cnt_r != 3'd0);
  assign last_piece = rec_pend_r ? (ack_cnt_r == 3'd0) : (ack_cnt_r == 3'd1);
  assign in_s.ready = !out_valid || (out_m.ready && last_piece);
  assign in_fire    = in_s.valid && in_s.ready;
  assign out_fire   = out_valid && out_m.ready;

  always_comb begin
    rec_pend_nxt = rec_pend_r;
    ack_cnt_nxt  = ack_cnt_r;
    if (in_fire) begin
      rec_pend_nxt = rec_ok;
      ack_cnt_nxt  = ack_go ? CONNACK_LEN : 3'd0;
    end else if (out_fire) begin
      if (rec_pend_r) rec_pend_nxt = 1'b0;
      else ack_cnt_nxt = ack_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      accum_r    <= '0;
      len_cnt_r  <= '0;
      type_r     <= '0;
      hflags_r   <= '0;
      level_r    <= '0;
      cflags_r   <= '0;
      hold_r     <= '0;
      tag_r      <= '0;
      left_r     <= '0;
      rec_pend_r <= 1'b0;
      ack_cnt_r  <= '0;
    end else begin
      if (in_fire) begin
        phase_r   <= phase_nxt;
        accum_r   <= accum_nxt;
        len_cnt_r <= len_cnt_nxt;
        type_r    <= type_nxt;
        hflags_r  <= hflags_nxt;
        level_r   <= level_nxt;
        cflags_r  <= cflags_nxt;
        hold_r    <= hold_nxt;
        tag_r     <= tag_nxt;
        left_r    <= left_nxt;
      end
      rec_pend_r <= rec_pend_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) rec_r <= rec_c;
  end

  always_comb begin
    ack_rec             = '0;
    ack_rec.record_kind = KIND_CONNACK;
    ack_rec.last        = (ack_cnt_r == 3'd1);
    case (ack_cnt_r)
      3'd4:    ack_rec.out_byte = CONNACK_BYTE0;
      3'd3:    ack_rec.out_byte = CONNACK_BYTE1;
      default: ack_rec.out_byte = CONNACK_ZERO;
    endcase
  end

  assign out_rec = rec_pend_r ? rec_r : ack_rec;

  assign out_m.valid         = out_valid;
  assign out_m.record_kind   = out_rec.record_kind;
  assign out_m.packet_type   = out_rec.packet_type;
  assign out_m.header_flags  = out_rec.header_flags;
  assign out_m.rem_len       = out_rec.rem_len;
  assign out_m.proto_level   = out_rec.proto_level;
  assign out_m.connect_flags = out_rec.connect_flags;
  assign out_m.ka_secs       = out_rec.ka_secs;
  assign out_m.string_tag    = out_rec.string_tag;
  assign out_m.string_length = out_rec.string_length;
  assign out_m.out_byte      = out_rec.out_byte;
  assign out_m.last          = out_rec.last;

  // connack replay never holds more than four bytes
  a_ack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ack_cnt_r <= CONNACK_LEN)
    else $error("connack count out of range");

  // pending connack bytes only follow the end of the last field
  a_ack_skip: assert property (@(posedge clk) disable iff (!rst_n)
    ack_cnt_r != 3'd0 |-> phase_r == PH_SKIP)
    else $error("connack pending outside skip phase");

  // a record queued ahead of the connack is the final item of its string
  a_rec_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_pend_r && ack_cnt_r != 3'd0) |-> rec_r.last)
    else $error("record before connack not marked last");

  // a start byte always leads into the length field
  a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_s.packet_start) |=> phase_r == PH_LEN)
    else $error("start item did not enter length phase");

endmodule
